FILE: sv/ikvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikvp_pkg: shared types and constants of the indented key/value line parser
// Character codes, directive patterns and the result word layout.
// ----------------------------------------------------------------------------
package ikvp_pkg;

	// default line buffer size and offset width
	localparam int LineBytesDef = 1024;
	localparam int PosW = 10;

	// character codes
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChBang   = 8'h21;
	localparam logic [7:0] ChHash   = 8'h23;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChLf     = 8'h0A;

	// directive patterns: "!ht", "!ci", "!hyphen", "!case-i"
	localparam int NumDir = 4;
	localparam int DirMax = 7;
	localparam logic [2:0] DirLen [NumDir] = '{3'd3, 3'd3, 3'd7, 3'd7};
	localparam logic [7:0] DirPat [NumDir][DirMax] = '{
		'{ChBang, 8'h68, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},
		'{ChBang, 8'h63, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00},
		'{ChBang, 8'h68, 8'h79, 8'h70, 8'h68, 8'h65, 8'h6E},
		'{ChBang, 8'h63, 8'h61, 8'h73, 8'h65, 8'h2D, 8'h69}
	};

	// directive result codes
	typedef enum logic [1:0] {
		DirNone   = 2'd0,
		DirHyphen = 2'd1,
		DirNocase = 2'd2
	} dir_code_t;

	// one result word
	typedef struct packed {
		logic [PosW-1:0] indent_level;
		logic            has_tag;
		logic [PosW-1:0] tag_start;
		logic [PosW-1:0] tag_length;
		logic            value_present;
		logic [PosW-1:0] value_start;
		logic [PosW-1:0] value_length;
		logic [1:0]      directive;
		logic            hyphen_mode;
		logic            nocase_mode;
	} result_t;

	// space, tab, lf, vt, ff, cr
	function automatic logic is_ws(input logic [7:0] c);
		return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
	endfunction

endpackage

FILE: sv/ikvp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikvp_if: byte and result channels of the line parser
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ikvp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       line_end;

	modport source (output valid, output ch, output line_end, input ready);
	modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface ikvp_res_if import ikvp_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/ikvp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikvp_core: per-byte phase machine and line counters
// Updates the line state for each accepted byte and forms the result word
// on the line-end byte; the state returns to start of line afterwards.
// ----------------------------------------------------------------------------
module ikvp_core import ikvp_pkg::*; #(
	parameter int LINE_BYTES = LineBytesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] ch,
	input  logic       line_end,
	output logic       res_valid,
	output result_t    res
);

	// offsets from the cap on are ignored
	localparam int PosCapI = ((LINE_BYTES - 1) < 1023) ? (LINE_BYTES - 1) : 1023;
	localparam logic [PosW-1:0] PosCap = PosW'(PosCapI);

	typedef enum logic [4:0] {
		PhLead  = 5'b00001,
		PhTag   = 5'b00010,
		PhColon = 5'b00100,
		PhValue = 5'b01000,
		PhDone  = 5'b10000
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [PosW-1:0]   pos_q, pos_n;
	logic [PosW-1:0]   level_q, level_n;
	logic [PosW-1:0]   tag_begin_q, tag_begin_n;
	logic [PosW-1:0]   tag_count_q, tag_count_n;
	logic [PosW-1:0]   val_begin_q, val_begin_n;
	logic              tag_seen_q, tag_seen_n;
	logic              val_seen_q, val_seen_n;
	logic              esc_q, esc_n;
	logic              tag_end_q, tag_end_n;
	logic [NumDir-1:0] match_q, match_n;
	logic              hyphen_q, hyphen_n;
	logic              nocase_q, nocase_n;

	// next-state logic for one byte
	always_comb begin
		logic      use_byte;
		logic      in_tag;
		logic      ws;
		dir_code_t dir;

		phase_n     = phase_q;
		pos_n       = pos_q;
		level_n     = level_q;
		tag_begin_n = tag_begin_q;
		tag_count_n = tag_count_q;
		val_begin_n = val_begin_q;
		tag_seen_n  = tag_seen_q;
		val_seen_n  = val_seen_q;
		esc_n       = esc_q;
		tag_end_n   = tag_end_q;
		match_n     = match_q;
		hyphen_n    = hyphen_q;
		nocase_n    = nocase_q;
		in_tag      = 1'b0;
		ws          = is_ws(ch);
		dir         = DirNone;
		res         = '0;
		res_valid   = take && line_end;

		// a newline on the line end is dropped, long lines are clipped
		use_byte = !(line_end && (ch == ChLf)) && (pos_q < PosCap);

		if (take && use_byte) begin
			// directive prefix match
			for (int k = 0; k < NumDir; k++) begin
				if ((pos_q < PosW'(DirLen[k])) && (ch != DirPat[k][pos_q[2:0]]))
					match_n[k] = 1'b0;
			end

			// leading whitespace
			if (phase_q == PhLead) begin
				if (ws) begin
					level_n = level_q + 1'b1;
				end else begin
					tag_seen_n  = 1'b1;
					tag_begin_n = pos_q;
					phase_n     = PhTag;
					in_tag      = 1'b1;
				end
			end else if (phase_q == PhTag) begin
				in_tag = 1'b1;
			end

			// tag scan with escapes
			if (in_tag) begin
				if (esc_q) begin
					esc_n = 1'b0;
				end else if (ch == ChBslash) begin
					esc_n = 1'b1;
				end else if ((ch == ChColon) || ws || (ch == ChHash)) begin
					if (!tag_end_q) begin
						tag_count_n = pos_q - tag_begin_n;
						tag_end_n   = 1'b1;
					end
					if (ch == ChColon)
						phase_n = PhColon;
					else if (ch == ChHash)
						phase_n = PhDone;
				end
			end else if (phase_q == PhColon) begin
				if (!ws) begin
					val_seen_n  = 1'b1;
					val_begin_n = pos_q;
					phase_n     = PhValue;
				end
			end

			pos_n = pos_q + 1'b1;
		end

		// result word at line end
		if (take && line_end) begin
			if ((pos_n == PosW'(3)) && match_n[0])
				dir = DirHyphen;
			else if ((pos_n == PosW'(3)) && match_n[1])
				dir = DirNocase;
			else if ((pos_n >= PosW'(7)) && match_n[2])
				dir = DirHyphen;
			else if ((pos_n >= PosW'(7)) && match_n[3])
				dir = DirNocase;

			if (dir == DirHyphen)
				hyphen_n = 1'b1;
			else if (dir == DirNocase)
				nocase_n = 1'b1;

			if (dir == DirNone) begin
				res.indent_level = level_n;
				if (tag_seen_n) begin
					res.has_tag    = 1'b1;
					res.tag_start  = tag_begin_n;
					res.tag_length = tag_end_n ? tag_count_n : (pos_n - tag_begin_n);
				end
				if (val_seen_n) begin
					res.value_present = 1'b1;
					res.value_start   = val_begin_n;
					res.value_length  = pos_n - val_begin_n;
				end
			end
			res.directive   = dir;
			res.hyphen_mode = hyphen_n;
			res.nocase_mode = nocase_n;

			// back to start of line
			phase_n     = PhLead;
			pos_n       = '0;
			level_n     = '0;
			tag_begin_n = '0;
			tag_count_n = '0;
			val_begin_n = '0;
			tag_seen_n  = 1'b0;
			val_seen_n  = 1'b0;
			esc_n       = 1'b0;
			tag_end_n   = 1'b0;
			match_n     = '1;
		end
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PhLead;
			pos_q       <= '0;
			level_q     <= '0;
			tag_begin_q <= '0;
			tag_count_q <= '0;
			val_begin_q <= '0;
			tag_seen_q  <= 1'b0;
			val_seen_q  <= 1'b0;
			esc_q       <= 1'b0;
			tag_end_q   <= 1'b0;
			match_q     <= '1;
			hyphen_q    <= 1'b0;
			nocase_q    <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_n;
			pos_q       <= pos_n;
			level_q     <= level_n;
			tag_begin_q <= tag_begin_n;
			tag_count_q <= tag_count_n;
			val_begin_q <= val_begin_n;
			tag_seen_q  <= tag_seen_n;
			val_seen_q  <= val_seen_n;
			esc_q       <= esc_n;
			tag_end_q   <= tag_end_n;
			match_q     <= match_n;
			hyphen_q    <= hyphen_n;
			nocase_q    <= nocase_n;
		end
	end

endmodule

FILE: sv/ikvp_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikvp_outbuf: two-entry result buffer
// Output register plus skid entry, so the byte side keeps moving while a
// finished result waits to be taken.
// ----------------------------------------------------------------------------
module ikvp_outbuf import ikvp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	ikvp_res_if.source results
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop            = out_valid_q && results.ready;
	assign space          = !skid_valid_q;
	assign results.valid  = out_valid_q;
	assign results.data   = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push && out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else if (pop) begin
				skid_valid_q <= 1'b0;
				out_valid_q  <= skid_valid_q || push;
			end else if (push) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push && out_valid_q && !pop)
			skid_q <= push_data;
		if (pop && skid_valid_q)
			out_q <= skid_q;
		else if (push && (!out_valid_q || pop))
			out_q <= push_data;
	end

endmodule

FILE: sv/indented_key_value_line_parser.sv
`timescale 1ns / 1ps
// the result word is registered in the output register when its line-end byte is taken,
//   or in the skid entry while an earlier result still holds the output register
// throughput: one byte per cycle; bytes stall only while both buffer entries
//   hold results that the sink has not taken
// reset: clears the line state, the sticky hyphen and case modes and the
//   result buffer
// ----------------------------------------------------------------------------
// indented_key_value_line_parser: top level of the line parser
// Byte-serial scan of indent, tag, value and mode directives of a text line.
// ----------------------------------------------------------------------------
module indented_key_value_line_parser import ikvp_pkg::*; #(
	parameter int LINE_BYTES = LineBytesDef
) (
	input  logic clk,
	input  logic arst_n,
	ikvp_byte_if.sink  bytes,
	ikvp_res_if.source results
);

	logic    take;
	logic    space;
	logic    res_valid;
	result_t res;

	// a byte word is taken whenever the skid entry is free
	assign bytes.ready = space;
	assign take        = bytes.valid && space;

	ikvp_core #(
		.LINE_BYTES(LINE_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.ch        (bytes.ch),
		.line_end  (bytes.line_end),
		.res_valid (res_valid),
		.res       (res)
	);

	ikvp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.results   (results)
	);

endmodule
